[src/csvt_pkg.sv]
// Package for the CSV field tokenizer: byte codes, kind codes, word types
// and the saturating index helpers. No dependencies.
package csvt_pkg;

  localparam int COLUMN_BITS = 8;
  localparam int ROW_BITS    = 16;
  localparam int COL_OUT_W   = 8;
  localparam int ROW_OUT_W   = 16;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_SEP     = 2'd1,
    KIND_ROW_END = 2'd2,
    KIND_REPEAT  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]           echo_byte;
    kind_t                byte_kind;
    logic [COL_OUT_W-1:0] column_index;
    logic [ROW_OUT_W-1:0] row_index;
    logic                 field_done;
    logic                 row_done;
    logic                 quoted;
  } out_word_t;

  // Counter value clamped to the width of the output index
  function automatic logic [COL_OUT_W-1:0] col_clamp(input logic [COLUMN_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'((64'd1 << COL_OUT_W) - 64'd1)) ? {COL_OUT_W{1'b1}} : w[COL_OUT_W-1:0];
  endfunction

  function automatic logic [ROW_OUT_W-1:0] row_clamp(input logic [ROW_BITS-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'((64'd1 << ROW_OUT_W) - 64'd1)) ? {ROW_OUT_W{1'b1}} : w[ROW_OUT_W-1:0];
  endfunction

endpackage

[src/csvt_in_if.sv]
// Input channel of the CSV field tokenizer: valid/ready plus one text word.
// Standalone; no package needed.
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

[src/csvt_out_if.sv]
// Result channel of the CSV field tokenizer: valid/ready plus one result word.
// Standalone; no package needed.
interface csvt_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  echo_byte;
  logic [1:0]  byte_kind;
  logic [7:0]  column_index;
  logic [15:0] row_index;
  logic        field_done;
  logic        row_done;
  logic        quoted;

  modport source (output valid, output echo_byte, output byte_kind, output column_index,
                  output row_index, output field_done, output row_done, output quoted,
                  input ready);
  modport sink   (input valid, input echo_byte, input byte_kind, input column_index,
                  input row_index, input field_done, input row_done, input quoted,
                  output ready);
endinterface

[src/csv_field_tokenizer.sv]
// Top level of the CSV field tokenizer: input register, classifier and result
// register. Uses csvt_pkg, csvt_in_if, csvt_out_if and csvt_classify.

// One text byte in, one result word out, at a sustained rate of one byte per
// clock while out_ch.ready stays high. A byte is taken into the input register,
// classified combinationally from there and written to the result register
// once that register is empty or being read. The two registers form a short
// pipeline: while a result waits at the output, one more byte is still taken
// in, and in_ch.ready drops only when both stages are full. The last_byte flag
// closes an unterminated final row and returns quote state and counters to zero
// for the next stream. Column and row indices saturate instead of wrapping.
module csv_field_tokenizer (
  input  logic              clk,
  input  logic              rst_n,
  csvt_in_if.sink           in_ch,
  csvt_out_if.source        out_ch
);

  csvt_pkg::in_word_t  in_word_r;
  logic                in_valid_r;
  csvt_pkg::out_word_t res;
  csvt_pkg::out_word_t out_word_r;
  logic                out_valid_r;

  logic advance;
  logic in_take;

  assign advance  = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r.text_byte <= in_ch.text_byte;
      in_word_r.last_byte <= in_ch.last_byte;
    end
  end

  csvt_classify u_classify (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_word_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.echo_byte    = out_word_r.echo_byte;
  assign out_ch.byte_kind    = 2'(out_word_r.byte_kind);
  assign out_ch.column_index = out_word_r.column_index;
  assign out_ch.row_index    = out_word_r.row_index;
  assign out_ch.field_done   = out_word_r.field_done;
  assign out_ch.row_done     = out_word_r.row_done;
  assign out_ch.quoted       = out_word_r.quoted;

endmodule

[src/csvt_classify.sv]
// Byte classifier: quote/terminator state, column and row counters and the
// combinational result for the word held in the input register. Uses csvt_pkg.
module csvt_classify (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  csvt_pkg::in_word_t  item,
  output csvt_pkg::out_word_t res
);

  logic                             in_quote_r, in_quote_nxt;
  logic                             quote_single_r, quote_single_nxt;
  logic                             after_term_r, after_term_nxt;
  logic [csvt_pkg::COLUMN_BITS-1:0] field_cnt_r, field_cnt_nxt;
  logic [csvt_pkg::ROW_BITS-1:0]    row_cnt_r, row_cnt_nxt;

  logic [7:0] b;
  logic       is_term;
  logic       is_quote;
  logic [7:0] close_char;

  always_comb begin
    b          = item.text_byte;
    is_term    = (b == csvt_pkg::CH_CR) || (b == csvt_pkg::CH_LF);
    is_quote   = (b == csvt_pkg::CH_DQUOTE) || (b == csvt_pkg::CH_SQUOTE);
    close_char = quote_single_r ? csvt_pkg::CH_SQUOTE : csvt_pkg::CH_DQUOTE;

    in_quote_nxt     = in_quote_r;
    quote_single_nxt = quote_single_r;
    after_term_nxt   = after_term_r;
    field_cnt_nxt    = field_cnt_r;
    row_cnt_nxt      = row_cnt_r;

    res.echo_byte    = b;
    res.byte_kind    = csvt_pkg::KIND_CONTENT;
    res.column_index = csvt_pkg::col_clamp(field_cnt_r);
    res.row_index    = csvt_pkg::row_clamp(row_cnt_r);
    res.field_done   = 1'b0;
    res.row_done     = 1'b0;
    res.quoted       = 1'b0;

    if (is_term) begin
      if (after_term_r) begin
        res.byte_kind = csvt_pkg::KIND_REPEAT;
      end else begin
        res.byte_kind  = csvt_pkg::KIND_ROW_END;
        res.field_done = 1'b1;
        res.row_done   = 1'b1;
        field_cnt_nxt  = '0;
        row_cnt_nxt    = (&row_cnt_r) ? row_cnt_r : row_cnt_r + 1'b1;
        after_term_nxt = 1'b1;
      end
      // a line end always closes an open quote
      in_quote_nxt     = 1'b0;
      quote_single_nxt = 1'b0;
    end else begin
      after_term_nxt = 1'b0;
      if (in_quote_r) begin
        res.quoted = 1'b1;
        if (b == close_char) begin
          in_quote_nxt     = 1'b0;
          quote_single_nxt = 1'b0;
        end
      end else if (is_quote) begin
        res.quoted       = 1'b1;
        in_quote_nxt     = 1'b1;
        quote_single_nxt = (b == csvt_pkg::CH_SQUOTE);
      end else if (b == csvt_pkg::CH_COMMA) begin
        res.byte_kind  = csvt_pkg::KIND_SEP;
        res.field_done = 1'b1;
        field_cnt_nxt  = (&field_cnt_r) ? field_cnt_r : field_cnt_r + 1'b1;
      end
      // unterminated final line is closed here
      if (item.last_byte) begin
        res.field_done = 1'b1;
        res.row_done   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quote_r     <= 1'b0;
      quote_single_r <= 1'b0;
      after_term_r   <= 1'b0;
      field_cnt_r    <= '0;
      row_cnt_r      <= '0;
    end else if (fire) begin
      if (item.last_byte) begin
        in_quote_r     <= 1'b0;
        quote_single_r <= 1'b0;
        after_term_r   <= 1'b0;
        field_cnt_r    <= '0;
        row_cnt_r      <= '0;
      end else begin
        in_quote_r     <= in_quote_nxt;
        quote_single_r <= quote_single_nxt;
        after_term_r   <= after_term_nxt;
        field_cnt_r    <= field_cnt_nxt;
        row_cnt_r      <= row_cnt_nxt;
      end
    end
  end

endmodule

[tb/tb_top.sv]
// Self-checking bench for csv_field_tokenizer: a scoreboard class predicts every result word.
// Depends on csvt_pkg, csvt_in_if, csvt_out_if and the block itself; reads no files.
module tb_top;

  localparam int COL_W = csvt_pkg::COL_OUT_W;
  localparam int ROW_W = csvt_pkg::ROW_OUT_W;
  localparam longint unsigned COL_MAX = (64'd1 << COL_W) - 1;
  localparam longint unsigned ROW_MAX = (64'd1 << ROW_W) - 1;
  localparam int REPORT_LIMIT = 10;

  // Tracks tokenizer state and keeps the result words still owed by the block
  class csv_scoreboard;
    logic                             in_quote;
    logic                             single_quote;
    logic                             after_eol;
    logic [csvt_pkg::COLUMN_BITS-1:0] field_cnt;
    logic [csvt_pkg::ROW_BITS-1:0]    row_cnt;
    csvt_pkg::out_word_t              owed_q[$];
    int                               mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      in_quote     = 1'b0;
      single_quote = 1'b0;
      after_eol    = 1'b0;
      field_cnt    = '0;
      row_cnt      = '0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function bit clean();
      return (mismatches == 0) && (owed_q.size() == 0);
    endfunction

    // Called for every accepted input word
    function void note_input(logic [7:0] b, logic last);
      csvt_pkg::out_word_t w;
      longint unsigned     cv;
      longint unsigned     rv;
      cv = field_cnt;
      rv = row_cnt;
      w.echo_byte    = b;
      w.byte_kind    = csvt_pkg::KIND_CONTENT;
      w.column_index = COL_W'((cv > COL_MAX) ? COL_MAX : cv);
      w.row_index    = ROW_W'((rv > ROW_MAX) ? ROW_MAX : rv);
      w.field_done   = 1'b0;
      w.row_done     = 1'b0;
      w.quoted       = 1'b0;
      if (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF) begin
        // any run of CR/LF ends one row; the rest are marked as repeats
        if (after_eol) begin
          w.byte_kind = csvt_pkg::KIND_REPEAT;
        end else begin
          w.byte_kind  = csvt_pkg::KIND_ROW_END;
          w.field_done = 1'b1;
          w.row_done   = 1'b1;
          field_cnt    = '0;
          if (row_cnt != '1) row_cnt = row_cnt + 1'b1;
          after_eol    = 1'b1;
        end
        in_quote     = 1'b0;
        single_quote = 1'b0;
      end else begin
        after_eol = 1'b0;
        if (in_quote) begin
          w.quoted = 1'b1;
          if (b == (single_quote ? csvt_pkg::CH_SQUOTE : csvt_pkg::CH_DQUOTE)) begin
            in_quote     = 1'b0;
            single_quote = 1'b0;
          end
        end else if (b == csvt_pkg::CH_DQUOTE || b == csvt_pkg::CH_SQUOTE) begin
          w.quoted     = 1'b1;
          in_quote     = 1'b1;
          single_quote = (b == csvt_pkg::CH_SQUOTE);
        end else if (b == csvt_pkg::CH_COMMA) begin
          w.byte_kind  = csvt_pkg::KIND_SEP;
          w.field_done = 1'b1;
          if (field_cnt != '1) field_cnt = field_cnt + 1'b1;
        end
        if (last) begin
          w.field_done = 1'b1;
          w.row_done   = 1'b1;
        end
      end
      if (last) clear_state();
      owed_q.push_back(w);
    endfunction

    // Called for every accepted result word
    function void check_result(csvt_pkg::out_word_t got);
      csvt_pkg::out_word_t w;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word: byte=%02h kind=%0d col=%0d row=%0d",
                   got.echo_byte, got.byte_kind, got.column_index, got.row_index);
        return;
      end
      w = owed_q.pop_front();
      if (got.echo_byte !== w.echo_byte || got.byte_kind !== w.byte_kind ||
          got.column_index !== w.column_index || got.row_index !== w.row_index ||
          got.field_done !== w.field_done || got.row_done !== w.row_done ||
          got.quoted !== w.quoted) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("exp: byte=%02h kind=%0d col=%0d row=%0d fd=%b rd=%b q=%b",
                   w.echo_byte, w.byte_kind, w.column_index, w.row_index,
                   w.field_done, w.row_done, w.quoted);
          $display("got: byte=%02h kind=%0d col=%0d row=%0d fd=%b rd=%b q=%b",
                   got.echo_byte, got.byte_kind, got.column_index, got.row_index,
                   got.field_done, got.row_done, got.quoted);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  csvt_in_if  in_bus();
  csvt_out_if out_bus();

  csv_field_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  csv_scoreboard board;
  int src_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int bytes_sent;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: ready changes on the falling edge; a hold request is counted down here
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_bus.ready = 1'b0;
        hold_left--;
      end else begin
        out_bus.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    csvt_pkg::out_word_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.echo_byte    = out_bus.echo_byte;
      got.byte_kind    = csvt_pkg::kind_t'(out_bus.byte_kind);
      got.column_index = out_bus.column_index;
      got.row_index    = out_bus.row_index;
      got.field_done   = out_bus.field_done;
      got.row_done     = out_bus.row_done;
      got.quoted       = out_bus.quoted;
      board.check_result(got);
    end
  end

  // Entered and left on a falling edge; valid stays high between back-to-back words
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.text_byte = b;
    in_bus.last_byte = last;
    do @(posedge clk); while (!in_bus.ready);
    board.note_input(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_bus.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == csvt_pkg::CH_CR || b == csvt_pkg::CH_LF || b == csvt_pkg::CH_COMMA ||
           b == csvt_pkg::CH_DQUOTE || b == csvt_pkg::CH_SQUOTE);
    return b;
  endfunction

  function automatic logic [7:0] pick_quote();
    return $urandom_range(1) ? csvt_pkg::CH_SQUOTE : csvt_pkg::CH_DQUOTE;
  endfunction

  task automatic send_field();
    int         style;
    int         len;
    logic [7:0] q;
    style = $urandom_range(9);
    len   = $urandom_range(5);
    q     = pick_quote();
    if (style <= 4) begin
      repeat (len) push_byte(plain_byte(), 1'b0);
    end else if (style <= 7) begin
      // quote at the start, or partway into the field
      if (style == 7) repeat ($urandom_range(1, 3)) push_byte(plain_byte(), 1'b0);
      push_byte(q, 1'b0);
      repeat (len) begin
        case ($urandom_range(3))
          0:       push_byte(csvt_pkg::CH_COMMA, 1'b0);
          1:       push_byte((q == csvt_pkg::CH_SQUOTE) ? csvt_pkg::CH_DQUOTE :
                             csvt_pkg::CH_SQUOTE, 1'b0);
          default: push_byte(plain_byte(), 1'b0);
        endcase
      end
      // now and then the span is left open until the line end
      if ($urandom_range(5) != 0) push_byte(q, 1'b0);
      if (style == 7) repeat ($urandom_range(2)) push_byte(plain_byte(), 1'b0);
    end else begin
      repeat (len) push_byte($urandom_range(1) ? plain_byte() : pick_quote(), 1'b0);
    end
  endtask

  task automatic send_row();
    int n_fields;
    int ending;
    if ($urandom_range(99) < 15) begin
      // noise: any byte, stray last flags
      repeat ($urandom_range(1, 10))
        push_byte(8'($urandom_range(255)), $urandom_range(19) == 0);
      return;
    end
    n_fields = $urandom_range(1, 6);
    for (int i = 0; i < n_fields; i++) begin
      if (i > 0) push_byte(csvt_pkg::CH_COMMA, 1'b0);
      send_field();
    end
    ending = $urandom_range(9);
    case (ending)
      0, 1, 2: push_byte(csvt_pkg::CH_LF, 1'b0);
      3, 4: begin
        push_byte(csvt_pkg::CH_CR, 1'b0);
        push_byte(csvt_pkg::CH_LF, 1'b0);
      end
      5: push_byte(csvt_pkg::CH_CR, 1'b0);
      6: repeat ($urandom_range(2, 5))
           push_byte($urandom_range(1) ? csvt_pkg::CH_CR : csvt_pkg::CH_LF, 1'b0);
      7: begin
        if ($urandom_range(1)) push_byte(csvt_pkg::CH_CR, 1'b0);
        push_byte(csvt_pkg::CH_LF, 1'b1);
      end
      default: begin
        // final line with no terminator
        case ($urandom_range(3))
          0:       push_byte(csvt_pkg::CH_COMMA, 1'b1);
          1:       push_byte(pick_quote(), 1'b1);
          default: push_byte(plain_byte(), 1'b1);
        endcase
      end
    endcase
  endtask

  task automatic send_rows(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_row();
  endtask

  task automatic send_directed();
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(csvt_pkg::CH_COMMA, 1'b0);
    push_byte(csvt_pkg::CH_DQUOTE, 1'b0);
    push_byte(csvt_pkg::CH_COMMA, 1'b0);   // comma inside quotes is content
    push_byte(csvt_pkg::CH_SQUOTE, 1'b0);  // other quote does not close
    push_byte(csvt_pkg::CH_DQUOTE, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(csvt_pkg::CH_SQUOTE, 1'b0);  // quote partway into a field
    push_byte(csvt_pkg::CH_CR, 1'b0);      // line end closes the open quote
    push_byte(csvt_pkg::CH_LF, 1'b0);
    push_byte(csvt_pkg::CH_CR, 1'b0);
    push_byte(8'h63, 1'b0);
    push_byte(csvt_pkg::CH_DQUOTE, 1'b0);
    push_byte(csvt_pkg::CH_LF, 1'b0);
    push_byte(8'h64, 1'b0);
    push_byte(csvt_pkg::CH_COMMA, 1'b1);   // separator as the final word
    push_byte(csvt_pkg::CH_LF, 1'b0);
    push_byte(csvt_pkg::CH_LF, 1'b1);      // repeat terminator as the final word
    push_byte(8'h7A, 1'b1);
    push_byte(csvt_pkg::CH_LF, 1'b1);
  endtask

  task automatic send_saturation();
    // enough separators to pin the column counter at its top value
    repeat (270) push_byte(csvt_pkg::CH_COMMA, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(csvt_pkg::CH_COMMA, 1'b0);
    push_byte(csvt_pkg::CH_LF, 1'b0);
    push_byte(csvt_pkg::CH_COMMA, 1'b0);
    push_byte(8'h79, 1'b1);
    push_byte(8'h7A, 1'b0);
    push_byte(csvt_pkg::CH_LF, 1'b1);
  endtask

  initial begin : stimulus
    int wait_cycles;
    board            = new();
    src_idle_pct     = 0;
    rx_idle_pct      = 0;
    hold_req         = 0;
    bytes_sent       = 0;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.text_byte = '0;
    in_bus.last_byte = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    src_idle_pct = 20;
    rx_idle_pct  = 65;
    send_directed();
    send_rows(330);
    settle();

    src_idle_pct = 65;
    rx_idle_pct  = 20;
    send_rows(330);
    settle();

    src_idle_pct = 0;
    rx_idle_pct  = 0;
    hold_req     = 400;
    send_rows(340);
    send_saturation();
    in_bus.valid = 1'b0;

    wait_cycles = 0;
    while (board.pending() != 0 && wait_cycles < 100000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);
    if (board.clean())
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
